// ----- hw/rtl/quadx_motor_mixer_defines.svh -----
// ----------------------------------------------------------------------------
// quadx motor mixer assertion macros
// shared property shapes for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef QUADX_MOTOR_MIXER_DEFINES_SVH
`define QUADX_MOTOR_MIXER_DEFINES_SVH

// same-cycle implication, off while reset is high
`define QXMM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is high
`define QXMM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/qxmm_pkg.sv -----
// ----------------------------------------------------------------------------
// qxmm_pkg
// widths, mix sign tables, register codes and shared types of the mixer
// ----------------------------------------------------------------------------
`default_nettype none

package qxmm_pkg;

  localparam int NUM_MOTORS = 4;
  localparam int THR_W      = 14;
  localparam int CORR_W     = 16;
  localparam int RAW_W      = 18;  // throttle plus three corrections, signed
  localparam int NUM_W      = 17;  // positive part of a raw demand
  localparam int CMD_W      = 11;
  localparam int DIFF_W     = CMD_W + 1;
  localparam int SUM_W      = CMD_W + 2;
  localparam int IDLE_W     = 10;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_INVERT_YAW = 2'd0,
    CFG_IDLE       = 2'd1,
    CFG_CMD_MIN    = 2'd2,
    CFG_CMD_MAX    = 2'd3
  } cfg_reg_e;

  localparam logic              RST_INVERT_YAW = 1'b0;
  localparam logic [IDLE_W-1:0] RST_IDLE       = 10'd55;
  localparam logic [CMD_W-1:0]  RST_CMD_MIN    = 11'd48;
  localparam logic [CMD_W-1:0]  RST_CMD_MAX    = 11'd2047;

  // bit set = term enters negated; motor order rr, fr, rl, fl
  localparam logic [NUM_MOTORS-1:0] ROLL_NEG  = 4'b0011;
  localparam logic [NUM_MOTORS-1:0] PITCH_NEG = 4'b1010;
  localparam logic [NUM_MOTORS-1:0] YAW_NEG   = 4'b1001;

  // floor(y / 1000) = (y * IDLE_RECIP) >> IDLE_RECIP_SHIFT, exact for y below 6e6
  localparam int IDLE_PA_W        = 21;
  localparam int IDLE_PB_W        = 20;
  localparam int IDLE_RECIP_W     = 21;
  localparam int IDLE_RECIP_SHIFT = 30;
  localparam int IDLE_T_W         = IDLE_PB_W + IDLE_RECIP_W;
  localparam int IDLE_FRAC_W      = IDLE_T_W - IDLE_RECIP_SHIFT;
  localparam logic [IDLE_RECIP_W-1:0] IDLE_RECIP = 21'd1073742;

  typedef struct packed {
    logic valid;
    logic armed;
  } ctl_t;

  typedef logic [NUM_MOTORS-1:0][CMD_W-1:0] cmd_vec_t;

endpackage

`default_nettype wire

// ----- hw/rtl/qxmm_mix.sv -----
// ----------------------------------------------------------------------------
// qxmm_mix
// two stages: signed mix into four raw demands, then positive part and
// the desaturation divisor (largest of full scale and the four demands)
// ----------------------------------------------------------------------------
`default_nettype none

module qxmm_mix import qxmm_pkg::*; #(
  parameter int FRAC_BITS = 13,
  parameter int DW        = 17
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                en,
  input  wire logic                                in_valid,
  input  wire logic                                armed,
  input  wire logic        [THR_W-1:0]             throttle,
  input  wire logic signed [CORR_W-1:0]            roll_correction,
  input  wire logic signed [CORR_W-1:0]            pitch_correction,
  input  wire logic signed [CORR_W-1:0]            yaw_correction,
  input  wire logic                                invert_yaw,
  output ctl_t                                     ctl_out,
  output logic             [NUM_MOTORS-1:0][DW-1:0] num,
  output logic             [DW-1:0]                den
);

  localparam logic [DW-1:0] ONE_D = {{(DW-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic signed [RAW_W-1:0] thr_s, roll_s, pitch_s, yaw_s;
  logic signed [RAW_W-1:0] raw_next [NUM_MOTORS];
  logic signed [RAW_W-1:0] raw      [NUM_MOTORS];
  ctl_t                    ctl1;

  logic [NUM_MOTORS-1:0][DW-1:0] num_c;
  logic [DW-1:0]                 m01, m23, m_all, den_next;

  assign thr_s   = {{(RAW_W-THR_W){1'b0}}, throttle};
  assign roll_s  = {{(RAW_W-CORR_W){roll_correction[CORR_W-1]}}, roll_correction};
  assign pitch_s = {{(RAW_W-CORR_W){pitch_correction[CORR_W-1]}}, pitch_correction};
  assign yaw_s   = {{(RAW_W-CORR_W){yaw_correction[CORR_W-1]}}, yaw_correction};

  always_comb begin
    for (int i = 0; i < NUM_MOTORS; i++) begin
      raw_next[i] = thr_s
                  + (ROLL_NEG[i]  ? -roll_s  : roll_s)
                  + (PITCH_NEG[i] ? -pitch_s : pitch_s)
                  + ((YAW_NEG[i] ^ invert_yaw) ? -yaw_s : yaw_s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else if (en) begin
      ctl1 <= '{valid: in_valid, armed: armed};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        raw[i] <= raw_next[i];
      end
    end
  end

  // negative demands scale to zero
  always_comb begin
    for (int i = 0; i < NUM_MOTORS; i++) begin
      num_c[i] = raw[i][RAW_W-1] ? '0 : DW'(raw[i][NUM_W-1:0]);
    end
  end

  assign m01      = (num_c[1] > num_c[0]) ? num_c[1] : num_c[0];
  assign m23      = (num_c[3] > num_c[2]) ? num_c[3] : num_c[2];
  assign m_all    = (m23 > m01) ? m23 : m01;
  assign den_next = (m_all > ONE_D) ? m_all : ONE_D;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num <= num_c;
      den <= den_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/qxmm_div.sv -----
// ----------------------------------------------------------------------------
// qxmm_div
// four-lane restoring divider, one quotient bit per stage:
// v = floor(num * 2^FRAC_BITS / den) with num <= den, so v <= 2^FRAC_BITS
// ----------------------------------------------------------------------------
`default_nettype none

module qxmm_div import qxmm_pkg::*; #(
  parameter int FRAC_BITS = 13,
  parameter int DW        = 17
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   en,
  input  wire ctl_t                                   ctl_in,
  input  wire logic [NUM_MOTORS-1:0][DW-1:0]          num,
  input  wire logic [DW-1:0]                          den,
  output ctl_t                                        ctl_out,
  output logic      [NUM_MOTORS-1:0][FRAC_BITS:0]     v
);

  localparam int NS = FRAC_BITS + 1;

  ctl_t                               ctl_st [NS];
  logic [NUM_MOTORS-1:0][FRAC_BITS:0] quo_st [NS];
  logic [NUM_MOTORS-1:0][DW-1:0]      rem_st [NS-1];
  logic [DW-1:0]                      den_st [NS-1];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    ctl_t                               c_in;
    logic [DW-1:0]                      d_in;
    logic [NUM_MOTORS-1:0][DW:0]        trial;
    logic [NUM_MOTORS-1:0][FRAC_BITS:0] q_in;
    logic [NUM_MOTORS-1:0]              ge;

    if (j == 0) begin : g_first
      // top quotient bit: no shift, remainder starts as the numerator
      assign c_in = ctl_in;
      assign d_in = den;
      for (genvar i = 0; i < NUM_MOTORS; i++) begin : g_lane
        assign trial[i] = {1'b0, num[i]};
        assign q_in[i]  = '0;
      end
    end else begin : g_next
      assign c_in = ctl_st[j-1];
      assign d_in = den_st[j-1];
      for (genvar i = 0; i < NUM_MOTORS; i++) begin : g_lane
        assign trial[i] = {rem_st[j-1][i], 1'b0};
        assign q_in[i]  = quo_st[j-1][i];
      end
    end

    always_comb begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        ge[i] = (trial[i] >= {1'b0, d_in});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_st[j] <= '0;
      end else if (en) begin
        ctl_st[j] <= c_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < NUM_MOTORS; i++) begin
          quo_st[j][i] <= {q_in[i][FRAC_BITS-1:0], ge[i]};
        end
      end
    end

    // the last stage keeps no remainder or divisor
    if (j < NS - 1) begin : g_rem
      logic [NUM_MOTORS-1:0][DW-1:0] rem_next;

      always_comb begin
        for (int i = 0; i < NUM_MOTORS; i++) begin
          rem_next[i] = ge[i] ? DW'(trial[i] - {1'b0, d_in}) : trial[i][DW-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_st[j] <= rem_next;
          den_st[j] <= d_in;
        end
      end
    end
  end

  assign ctl_out = ctl_st[NS-1];
  assign v       = quo_st[NS-1];

endmodule

`default_nettype wire

// ----- hw/rtl/qxmm_map.sv -----
// ----------------------------------------------------------------------------
// qxmm_map
// idle floor and full-scale limit, then linear map onto the command range;
// also derives the idle floor in fixed point from its register
// ----------------------------------------------------------------------------
`default_nettype none

module qxmm_map import qxmm_pkg::*; #(
  parameter int FRAC_BITS = 13
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  en,
  input  wire ctl_t                                  ctl_in,
  input  wire logic [NUM_MOTORS-1:0][FRAC_BITS:0]    v,
  input  wire logic [IDLE_W-1:0]                     idle_tenths_percent,
  input  wire logic [CMD_W-1:0]                      command_min,
  input  wire logic [CMD_W-1:0]                      command_max,
  output ctl_t                                       ctl_out,
  output cmd_vec_t                                   cmd
);

  localparam int PW = FRAC_BITS + SUM_W;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  // 2^FRAC_BITS = 1000 * IDLE_A + IDLE_B
  localparam logic [CMD_W-1:0]  IDLE_A = CMD_W'((1 << FRAC_BITS) / 1000);
  localparam logic [IDLE_W-1:0] IDLE_B = IDLE_W'((1 << FRAC_BITS) % 1000);

  // idle floor: idle * IDLE_A + floor(idle * IDLE_B / 1000), registered
  logic [IDLE_PA_W-1:0]   idle_pa, idle_pa_d, idle_sum;
  logic [IDLE_PB_W-1:0]   idle_pb;
  logic [IDLE_T_W-1:0]    idle_t;
  logic [IDLE_FRAC_W-1:0] idle_frac;
  logic [FRAC_BITS:0]     idle_q;

  assign idle_t   = {{(IDLE_T_W-IDLE_PB_W){1'b0}}, idle_pb}
                  * {{(IDLE_T_W-IDLE_RECIP_W){1'b0}}, IDLE_RECIP};
  assign idle_sum = idle_pa_d + {{(IDLE_PA_W-IDLE_FRAC_W){1'b0}}, idle_frac};

  always_ff @(posedge clk) begin
    idle_pa   <= {{(IDLE_PA_W-IDLE_W){1'b0}}, idle_tenths_percent}
               * {{(IDLE_PA_W-CMD_W){1'b0}}, IDLE_A};
    idle_pb   <= {{(IDLE_PB_W-IDLE_W){1'b0}}, idle_tenths_percent}
               * {{(IDLE_PB_W-IDLE_W){1'b0}}, IDLE_B};
    idle_pa_d <= idle_pa;
    idle_frac <= idle_t[IDLE_T_W-1:IDLE_RECIP_SHIFT];
    idle_q    <= idle_sum[FRAC_BITS:0];
  end

  logic signed [DIFF_W-1:0] diff;
  logic [FRAC_BITS:0]       vf [NUM_MOTORS];
  logic [FRAC_BITS:0]       vc [NUM_MOTORS];
  logic signed [PW-1:0]     prod_next [NUM_MOTORS];
  logic signed [PW-1:0]     prod      [NUM_MOTORS];
  ctl_t                     ctl_m1;

  assign diff = $signed({1'b0, command_max}) - $signed({1'b0, command_min});

  always_comb begin
    for (int i = 0; i < NUM_MOTORS; i++) begin
      vf[i] = (v[i] < idle_q) ? idle_q : v[i];
      vc[i] = (vf[i] > ONE) ? ONE : vf[i];
      prod_next[i] = $signed({{(PW-FRAC_BITS-1){1'b0}}, vc[i]})
                   * $signed({{(PW-DIFF_W){diff[DIFF_W-1]}}, diff});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_m1 <= '0;
    end else if (en) begin
      ctl_m1 <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        prod[i] <= prod_next[i];
      end
    end
  end

  // arithmetic shift floors toward minus infinity, so a falling range rounds down
  logic signed [SUM_W-1:0] cmd_sum [NUM_MOTORS];
  cmd_vec_t                cmd_next;

  always_comb begin
    for (int i = 0; i < NUM_MOTORS; i++) begin
      cmd_sum[i]  = $signed({2'b00, command_min}) + $signed(prod[i][PW-1:FRAC_BITS]);
      cmd_next[i] = ctl_m1.armed ? cmd_sum[i][CMD_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd <= cmd_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/quadx_motor_mixer.sv -----
// ----------------------------------------------------------------------------
// quadx_motor_mixer
// QuadX mixer with desaturation: throttle and roll/pitch/yaw corrections in,
// four motor commands out.
// Input words arrive on in_valid/in_ready, one command word leaves on
// out_valid/out_ready for every input word, in order. The user must write
// registers on the cfg port (cfg_ready is always high) only while no word
// is in flight; the block itself does not enforce this. Throughput is one
// word per cycle while the catch entry is empty. The path holds two mix
// stages, FRAC_BITS + 1 divider stages (one quotient bit each), two map
// stages and the output register. Reset empties the pipeline and loads
// the register defaults; the derived idle floor settles in its own
// registers after reset or after its register write. When the receiver
// stalls, a second output entry catches the word in flight; in_ready then
// drops and the whole pipeline holds until the stored word moves up.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quadx_motor_mixer_defines.svh"

module quadx_motor_mixer import qxmm_pkg::*; #(
  parameter int FRAC_BITS = 13
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     armed,
  input  wire logic        [THR_W-1:0]  throttle,
  input  wire logic signed [CORR_W-1:0] roll_correction,
  input  wire logic signed [CORR_W-1:0] pitch_correction,
  input  wire logic signed [CORR_W-1:0] yaw_correction,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic             [CMD_W-1:0]  motor_rear_right,
  output logic             [CMD_W-1:0]  motor_front_right,
  output logic             [CMD_W-1:0]  motor_rear_left,
  output logic             [CMD_W-1:0]  motor_front_left,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

  localparam int DW = (FRAC_BITS + 1 > NUM_W) ? FRAC_BITS + 1 : NUM_W;

  // configuration registers
  logic              invert_yaw;
  logic [IDLE_W-1:0] idle_tenths_percent;
  logic [CMD_W-1:0]  command_min;
  logic [CMD_W-1:0]  command_max;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      invert_yaw          <= RST_INVERT_YAW;
      idle_tenths_percent <= RST_IDLE;
      command_min         <= RST_CMD_MIN;
      command_max         <= RST_CMD_MAX;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_INVERT_YAW: invert_yaw          <= cfg_data[0];
        CFG_IDLE:       idle_tenths_percent <= cfg_data[IDLE_W-1:0];
        CFG_CMD_MIN:    command_min         <= cfg_data[CMD_W-1:0];
        CFG_CMD_MAX:    command_max         <= cfg_data[CMD_W-1:0];
        default:        ;
      endcase
    end
  end

  // pipeline advances as a whole unless the second output entry is full
  logic     en;
  logic     skid_valid;
  logic     up_fire;
  ctl_t     mix_ctl, div_ctl, map_ctl;
  cmd_vec_t map_cmd, out_cmd, skid_cmd;

  logic [NUM_MOTORS-1:0][DW-1:0]      mix_num;
  logic [DW-1:0]                      mix_den;
  logic [NUM_MOTORS-1:0][FRAC_BITS:0] div_v;

  assign en       = !skid_valid;
  assign in_ready = en;
  assign up_fire  = map_ctl.valid && en;

  qxmm_mix #(
    .FRAC_BITS (FRAC_BITS),
    .DW        (DW)
  ) u_mix (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .in_valid         (in_valid),
    .armed            (armed),
    .throttle         (throttle),
    .roll_correction  (roll_correction),
    .pitch_correction (pitch_correction),
    .yaw_correction   (yaw_correction),
    .invert_yaw       (invert_yaw),
    .ctl_out          (mix_ctl),
    .num              (mix_num),
    .den              (mix_den)
  );

  qxmm_div #(
    .FRAC_BITS (FRAC_BITS),
    .DW        (DW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (mix_ctl),
    .num     (mix_num),
    .den     (mix_den),
    .ctl_out (div_ctl),
    .v       (div_v)
  );

  qxmm_map #(
    .FRAC_BITS (FRAC_BITS)
  ) u_map (
    .clk                 (clk),
    .rst                 (rst),
    .en                  (en),
    .ctl_in              (div_ctl),
    .v                   (div_v),
    .idle_tenths_percent (idle_tenths_percent),
    .command_min         (command_min),
    .command_max         (command_max),
    .ctl_out             (map_ctl),
    .cmd                 (map_cmd)
  );

  // two-entry output buffer: output register plus one catch entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= up_fire;
      end
    end else if (up_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_cmd <= skid_cmd;
      end else if (up_fire) begin
        out_cmd <= map_cmd;
      end
    end
    if (up_fire && out_valid && !out_ready) begin
      skid_cmd <= map_cmd;
    end
  end

  assign motor_rear_right  = out_cmd[0];
  assign motor_front_right = out_cmd[1];
  assign motor_rear_left   = out_cmd[2];
  assign motor_front_left  = out_cmd[3];

  `QXMM_ASSERT_IMP(a_skid_behind_out, clk, rst, skid_valid, out_valid, "catch entry full while output empty")
  `QXMM_ASSERT_NXT(a_skid_drains, clk, rst, out_valid && out_ready && skid_valid, out_valid && !skid_valid, "catch entry did not move up")
  `QXMM_ASSERT_NXT(a_stall_caught, clk, rst, out_valid && !out_ready && up_fire, skid_valid, "word lost at output stall")

endmodule

`default_nettype wire

// ----- tb/quadx_motor_mixer_tb.sv -----
// ----------------------------------------------------------------------------
// quadx_motor_mixer_tb
// Drives throttle and roll/pitch/yaw correction words into the mixer and
// checks every command word against an in-bench prediction of the mix,
// desaturation, idle floor and command mapping. Register settings change
// between phases, and both sides pause at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quadx_motor_mixer_tb;
  import qxmm_pkg::*;

  localparam int FRAC_BITS = 13;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int LATENCY   = FRAC_BITS + 5;

  typedef struct packed {
    logic [CMD_W-1:0] rear_right;
    logic [CMD_W-1:0] front_right;
    logic [CMD_W-1:0] rear_left;
    logic [CMD_W-1:0] front_left;
  } motor_cmd_t;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic                       armed;
  logic        [THR_W-1:0]    throttle;
  logic signed [CORR_W-1:0]   roll_correction;
  logic signed [CORR_W-1:0]   pitch_correction;
  logic signed [CORR_W-1:0]   yaw_correction;
  logic                       out_valid;
  logic                       out_ready;
  logic        [CMD_W-1:0]    motor_rear_right;
  logic        [CMD_W-1:0]    motor_front_right;
  logic        [CMD_W-1:0]    motor_rear_left;
  logic        [CMD_W-1:0]    motor_front_left;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_INDEX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  // register shadow
  logic                       yaw_inverted;
  logic [IDLE_W-1:0]          idle_tenths;
  logic [CMD_W-1:0]           cmd_min_reg;
  logic [CMD_W-1:0]           cmd_max_reg;

  motor_cmd_t                 pending_cmds[$];
  int                         mismatches;
  bit                         src_idle_en;
  bit                         sink_stall_en;

  quadx_motor_mixer #(
    .FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .armed            (armed),
    .throttle         (throttle),
    .roll_correction  (roll_correction),
    .pitch_correction (pitch_correction),
    .yaw_correction   (yaw_correction),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .motor_rear_right (motor_rear_right),
    .motor_front_right(motor_front_right),
    .motor_rear_left  (motor_rear_left),
    .motor_front_left (motor_front_left),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mix, desaturate, clamp and map one word with the current register shadow
  function automatic motor_cmd_t predict_motor_cmds(
    input logic                     arm,
    input logic [THR_W-1:0]         thr,
    input logic signed [CORR_W-1:0] roll,
    input logic signed [CORR_W-1:0] pitch,
    input logic signed [CORR_W-1:0] yaw
  );
    // motor order rr, fr, rl, fl
    int         roll_sign[4];
    int         pitch_sign[4];
    int         yaw_sign[4];
    longint     demand[4];
    longint     cmd[4];
    longint     t, r, p, y, peak, idle_q, lo, span, v, prod;
    motor_cmd_t res;
    roll_sign  = '{-1, -1, 1, 1};
    pitch_sign = '{1, -1, 1, -1};
    yaw_sign   = '{-1, 1, 1, -1};
    res = '0;
    if (!arm) return res;
    t = thr;
    r = roll;
    p = pitch;
    y = yaw;
    if (yaw_inverted) y = -y;
    peak = ONE;
    for (int m = 0; m < 4; m++) begin
      demand[m] = t + roll_sign[m] * r + pitch_sign[m] * p + yaw_sign[m] * y;
      if (demand[m] > peak) peak = demand[m];
    end
    idle_q = (longint'(idle_tenths) * ONE) / 1000;
    lo     = cmd_min_reg;
    span   = longint'(cmd_max_reg) - lo;
    for (int m = 0; m < 4; m++) begin
      v = (demand[m] > 0) ? (demand[m] * ONE) / peak : 0;
      if (v < idle_q) v = idle_q;
      if (v > ONE) v = ONE;
      prod = v * span;
      // floor of the exact sum, also for a downward range
      if (prod >= 0) cmd[m] = lo + prod / ONE;
      else cmd[m] = lo - (-prod + ONE - 1) / ONE;
      if (cmd[m] < 0) cmd[m] = 0;
    end
    res.rear_right  = cmd[0][CMD_W-1:0];
    res.front_right = cmd[1][CMD_W-1:0];
    res.rear_left   = cmd[2][CMD_W-1:0];
    res.front_left  = cmd[3][CMD_W-1:0];
    return res;
  endfunction

  // mostly short pauses, a few long ones
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(6, 40);
  endfunction

  function automatic logic signed [CORR_W-1:0] rand_corr();
    int pick;
    int near_val;
    pick     = $urandom_range(0, 19);
    near_val = $urandom_range(0, 4096);
    if (pick < 12) return CORR_W'(near_val - 2048);
    else if (pick < 17) return CORR_W'($urandom);
    else if (pick == 17) return 16'sh8000;
    else if (pick == 18) return 16'sh7fff;
    else return '0;
  endfunction

  task automatic send_word(
    input logic                     arm,
    input logic [THR_W-1:0]         thr,
    input logic signed [CORR_W-1:0] roll,
    input logic signed [CORR_W-1:0] pitch,
    input logic signed [CORR_W-1:0] yaw
  );
    int gap;
    gap = src_idle_en ? idle_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    armed            <= arm;
    throttle         <= thr;
    roll_correction  <= roll;
    pitch_correction <= pitch;
    yaw_correction   <= yaw;
    do @(posedge clk); while (!in_ready);
    pending_cmds.push_back(predict_motor_cmds(arm, thr, roll, pitch, yaw));
  endtask

  task automatic send_random_word();
    int               pick;
    logic [THR_W-1:0] thr;
    pick = $urandom_range(0, 19);
    if (pick < 14) thr = THR_W'($urandom_range(0, ONE));
    else if (pick < 18) thr = THR_W'($urandom);
    else if (pick == 18) thr = '1;
    else thr = THR_W'(ONE);
    send_word($urandom_range(0, 9) != 0, thr, rand_corr(), rand_corr(), rand_corr());
  endtask

  // stop sending and wait for every command word still in flight
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic load_settings(
    input logic [CFG_DATA_W-1:0] inv_word,
    input logic [CFG_DATA_W-1:0] idle_word,
    input logic [CFG_DATA_W-1:0] min_word,
    input logic [CFG_DATA_W-1:0] max_word
  );
    cfg_reg_e              idx;
    logic [CFG_DATA_W-1:0] word;
    for (int k = 0; k < 4; k++) begin
      idx = cfg_reg_e'(k);
      case (idx)
        CFG_INVERT_YAW: word = inv_word;
        CFG_IDLE:       word = idle_word;
        CFG_CMD_MIN:    word = min_word;
        default:        word = max_word;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= word;
      do @(posedge clk); while (!cfg_ready);
      case (idx)
        CFG_INVERT_YAW: yaw_inverted = word[0];
        CFG_IDLE:       idle_tenths  = word[IDLE_W-1:0];
        CFG_CMD_MIN:    cmd_min_reg  = word[CMD_W-1:0];
        default:        cmd_max_reg  = word[CMD_W-1:0];
      endcase
    end
    cfg_valid <= 1'b0;
    // let the derived idle floor settle
    repeat (4) @(posedge clk);
  endtask

  task automatic test_default_mix();
    send_word(1'b0, 14'h3fff, 16'sh8000, 16'sh7fff, -16'sd1);
    send_word(1'b1, 14'd0, 16'sd0, 16'sd0, 16'sd0);
    send_word(1'b1, 14'd8192, 16'sd0, 16'sd0, 16'sd0);
    send_word(1'b1, 14'h3fff, 16'sd0, 16'sd0, 16'sd0);
    send_word(1'b1, 14'd4096, 16'sh7fff, 16'sd0, 16'sd0);
    send_word(1'b1, 14'd4096, 16'sh8000, 16'sd0, 16'sd0);
    send_word(1'b1, 14'd4096, 16'sd0, 16'sh7fff, 16'sd0);
    send_word(1'b1, 14'd4096, 16'sd0, 16'sh8000, 16'sd0);
    send_word(1'b1, 14'd4096, 16'sd0, 16'sd0, 16'sh7fff);
    send_word(1'b1, 14'd4096, 16'sd0, 16'sd0, 16'sh8000);
    // all three corrections at the same extreme
    send_word(1'b1, 14'd0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_word(1'b1, 14'h3fff, 16'sh8000, 16'sh8000, 16'sh8000);
  endtask

  task automatic test_invert_yaw();
    drain();
    load_settings(11'h7ff, 11'd55, 11'd48, 11'd2047);
    send_word(1'b1, 14'd4096, 16'sd0, 16'sd0, 16'sh7fff);
    send_word(1'b1, 14'd4096, 16'sd300, -16'sd200, -16'sd8192);
  endtask

  task automatic test_idle_floor();
    drain();
    load_settings(11'd0, 11'd0, 11'd0, 11'd2047);
    send_word(1'b1, 14'd0, 16'sd0, 16'sd0, 16'sd0);
    send_word(1'b1, 14'd2000, 16'sd100, -16'sd300, 16'sd50);
    drain();
    load_settings(11'd0, 11'd1000, 11'd0, 11'd2047);
    send_word(1'b1, 14'd0, 16'sd0, 16'sd0, 16'sd0);
    drain();
    // idle above full scale, upper data bit dropped by the register
    load_settings(11'd0, 11'h7ff, 11'd48, 11'd2047);
    send_word(1'b1, 14'd0, 16'sh8000, 16'sd0, 16'sd0);
    send_word(1'b1, 14'd8192, 16'sd1234, 16'sd0, -16'sd99);
  endtask

  task automatic test_inverted_range();
    drain();
    load_settings(11'd0, 11'd55, 11'd2047, 11'd0);
    send_word(1'b1, 14'd0, 16'sd0, 16'sd0, 16'sd0);
    send_word(1'b1, 14'd4096, 16'sd1000, -16'sd2000, 16'sd300);
    send_word(1'b1, 14'd8192, 16'sd0, 16'sd0, 16'sd0);
    drain();
    load_settings(11'd1, 11'd500, 11'd1000, 11'd1000);
    send_word(1'b1, 14'd5000, -16'sd700, 16'sd800, 16'sd900);
  endtask

  task automatic test_random_words();
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: load_settings(11'd0, 11'd55, 11'd48, 11'd2047);
        1: load_settings(11'd1, 11'd0, 11'd0, 11'd2047);
        2: load_settings(11'd0, 11'd1000, 11'd2047, 11'd0);
        3: load_settings(11'd1, 11'd1023, 11'd2047, 11'd2047);
        default: load_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(0, 1023)),
                               CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
      endcase
      src_idle_en   = (ph != 2);
      sink_stall_en = (ph != 3);
      repeat (125) send_random_word();
    end
  endtask

  initial begin
    rst              <= 1'b1;
    in_valid         <= 1'b0;
    armed            <= 1'b0;
    throttle         <= '0;
    roll_correction  <= '0;
    pitch_correction <= '0;
    yaw_correction   <= '0;
    cfg_valid        <= 1'b0;
    cfg_index        <= CFG_INVERT_YAW;
    cfg_data         <= '0;
    yaw_inverted     = RST_INVERT_YAW;
    idle_tenths      = RST_IDLE;
    cmd_min_reg      = RST_CMD_MIN;
    cmd_max_reg      = RST_CMD_MAX;
    mismatches       = 0;
    src_idle_en      = 1'b1;
    sink_stall_en    = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);

    test_default_mix();
    test_invert_yaw();
    test_idle_floor();
    test_inverted_range();
    test_random_words();

    drain();
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // receiver side: ready runs broken by stalls of random length
  initial begin : sink_ctl
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = sink_stall_en ? idle_gap() : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  task automatic check_field(input string name, input logic [CMD_W-1:0] want,
                             input logic [CMD_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin : cmd_check
    motor_cmd_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: command word with none expected: %0d %0d %0d %0d", $realtime,
                   motor_rear_right, motor_front_right, motor_rear_left, motor_front_left);
      end else begin
        want = pending_cmds.pop_front();
        check_field("motor_rear_right", want.rear_right, motor_rear_right);
        check_field("motor_front_right", want.front_right, motor_front_right);
        check_field("motor_rear_left", want.rear_left, motor_rear_left);
        check_field("motor_front_left", want.front_left, motor_front_left);
      end
    end
  end

  initial begin : watchdog
    #(10_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
